@@ src/graph_degeneracy_engine_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the graph degeneracy engine
// Clocked implication checks, reset-qualified, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef GRAPH_DEGENERACY_ENGINE_ASSERT_SVH
`define GRAPH_DEGENERACY_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define GDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/gde_pkg.sv @@
// ----------------------------------------------------------------------------
// gde_pkg
// Shared widths, request codes and sequencer states of the degeneracy engine.
// ----------------------------------------------------------------------------
package gde_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int DEG_W = CNT_W;

  localparam int REQ_W = 2;
  localparam int VTX_W = 7;
  localparam int OUT_W = 6;

  localparam logic [VTX_W-1:0] VC_RESET = VTX_W'(64);
  localparam logic [OUT_W-1:0] OUT_MAX  = '1;

  localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RMV = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DEG = 2'd2;

  typedef logic [MAX_VERTICES-1:0] row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_A,
    ST_ADD_B,
    ST_RMV,
    ST_SWEEP,
    ST_PICK
  } gde_state_t;

endpackage

@@ src/gde_popcnt.sv @@
// ----------------------------------------------------------------------------
// gde_popcnt
// Balanced adder tree counting the set bits of one adjacency row.
// ----------------------------------------------------------------------------
module gde_popcnt (
  input  gde_pkg::row_t             row,
  output logic [gde_pkg::DEG_W-1:0] count
);
  import gde_pkg::*;

  localparam int LVLS   = $clog2(MAX_VERTICES);
  localparam int LEAVES = 1 << LVLS;

  logic [DEG_W-1:0] node [1:2*LEAVES-1];

  // leaves: one bit each, pad past the row end with zero
  for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
    if (k < MAX_VERTICES) begin : g_bit
      assign node[LEAVES+k] = DEG_W'(row[k]);
    end else begin : g_pad
      assign node[LEAVES+k] = '0;
    end
  end

  for (genvar k = 1; k < LEAVES; k++) begin : g_sum
    assign node[k] = node[2*k] + node[2*k+1];
  end

  assign count = node[1];

endmodule

@@ src/graph_degeneracy_engine.sv @@
// ----------------------------------------------------------------------------
// graph_degeneracy_engine
// Adjacency-matrix graph store with an iterative k-core peeling sequencer.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; busy stays high
// until the command is done. Add edge holds busy through ST_ADD_A and ST_ADD_B
// (read-modify-write of both matrix rows), remove vertex through one
// read-modify-write sweep over all 64 rows to clear the column. An add or
// remove that names a vertex out of range, a self-loop and the unused request
// code are dropped at the accepting edge and leave busy low. Compute holds busy
// for p + 1 sweeps over the n vertices in use, p being the vertices peeled:
// each sweep walks the degree memory once through a one-read, one-write port
// with a two-stage pipeline, and the pick state sits between sweeps. The
// degeneracy word appears on out_degeneracy with out_valid for exactly one
// cycle right after busy falls; the receiver cannot stall it, so sample it
// then. Add edge, remove vertex and the unused request code give no result
// word. The matrix starts empty after reset through per-row valid flags, with
// no clearing pass. Write the vertex count only while busy is low; cfg_ready
// mirrors that.
// ----------------------------------------------------------------------------
module graph_degeneracy_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [gde_pkg::REQ_W-1:0] in_req_type,
  input  logic [gde_pkg::VTX_W-1:0] in_vertex_a,
  input  logic [gde_pkg::VTX_W-1:0] in_vertex_b,
  output logic                      out_valid,
  output logic [gde_pkg::OUT_W-1:0] out_degeneracy,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [gde_pkg::VTX_W-1:0] cfg_vertex_count
);
  import gde_pkg::*;

  // --- sequencer and control state
  gde_state_t       state_r, state_nxt;
  logic [VTX_W-1:0] vc_r, vc_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;        // sweep read pointer
  logic             init_r, init_nxt;  // first sweep builds the degrees
  logic             s1_v_r, s2_v_r;    // sweep pipeline valids
  row_t             removed_r, removed_nxt;
  row_t             row_vld_r, row_vld_nxt;
  logic             found_r, found_nxt;
  logic [DEG_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0] pick_r, pick_nxt;
  logic [OUT_W-1:0] max_r, max_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_deg_r, out_deg_nxt;

  // --- payload registers
  logic [IDX_W-1:0] a_r, b_r;
  logic [IDX_W-1:0] s1_idx_r, s2_idx_r;
  logic [DEG_W-1:0] s2_deg_r;
  row_t             adj_rd_r;
  logic             adj_rv_r;
  logic [DEG_W-1:0] deg_rd_r;

  // --- memories
  row_t             adj_mem [MAX_VERTICES];
  logic [DEG_W-1:0] deg_mem [MAX_VERTICES];

  // --- combinational helpers
  logic             accept;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] lim;
  logic             issue;
  logic             add_ok, rmv_ok;
  logic             adj_re, adj_we;
  logic [IDX_W-1:0] adj_ra, adj_wa;
  row_t             adj_wd;
  row_t             adj_eff;
  row_t             nmask;
  logic             deg_re;
  logic [DEG_W-1:0] pop;
  logic             dec;
  logic [DEG_W-1:0] s1_val;
  logic             cand;
  logic [OUT_W-1:0] best_sat;

  assign busy           = (state_r != ST_IDLE);
  assign cfg_ready      = !busy;
  assign out_valid      = out_valid_r;
  assign out_degeneracy = out_deg_r;
  assign accept         = start && (state_r == ST_IDLE);

  // Effective vertex count, capped at the matrix size.
  assign n_eff = (vc_r > VTX_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : CNT_W'(vc_r);

  assign add_ok = (in_vertex_a != '0) && (in_vertex_a <= VTX_W'(n_eff)) &&
                  (in_vertex_b != '0) && (in_vertex_b <= VTX_W'(n_eff)) &&
                  (in_vertex_a != in_vertex_b);
  assign rmv_ok = (in_vertex_a != '0) && (in_vertex_a <= VTX_W'(n_eff));

  // Column removal covers every row; compute sweeps the rows in use.
  assign lim   = (state_r == ST_RMV) ? CNT_W'(MAX_VERTICES) : n_eff;
  assign issue = ((state_r == ST_SWEEP) || (state_r == ST_RMV)) && (i_r < lim);

  // A row never written reads as empty.
  assign adj_eff = adj_rv_r ? adj_rd_r : '0;

  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      nmask[j] = (CNT_W'(j) < n_eff);
    end
  end

  gde_popcnt u_popcnt (
    .row   (adj_eff & nmask),
    .count (pop)
  );

  // Stage 1 of a sweep: initial degree from the row, or drop one for a
  // live neighbour of the vertex just peeled.
  assign dec    = adj_eff[s1_idx_r] && !removed_r[s1_idx_r] && (deg_rd_r != '0);
  assign s1_val = init_r ? pop : (deg_rd_r - DEG_W'(dec));

  // Stage 2: smallest positive degree, lowest index wins ties.
  assign cand = s2_v_r && !removed_r[s2_idx_r] && (s2_deg_r != '0) &&
                (!found_r || (s2_deg_r < best_r));

  assign best_sat = (best_r > DEG_W'(OUT_MAX)) ? OUT_MAX : best_r[OUT_W-1:0];

  assign deg_re = issue && (state_r == ST_SWEEP) && !init_r;

  // --- next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    vc_nxt        = vc_r;
    i_nxt         = i_r;
    init_nxt      = init_r;
    removed_nxt   = removed_r;
    row_vld_nxt   = row_vld_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    pick_nxt      = pick_r;
    max_nxt       = max_r;
    out_valid_nxt = 1'b0;
    out_deg_nxt   = out_deg_r;
    adj_re        = 1'b0;
    adj_ra        = i_r[IDX_W-1:0];
    adj_we        = 1'b0;
    adj_wa        = a_r;
    adj_wd        = adj_eff;

    if (cfg_valid && cfg_ready) begin
      vc_nxt = cfg_vertex_count;
    end

    if (issue) begin
      i_nxt = i_r + CNT_W'(1);
    end

    if (cand) begin
      found_nxt = 1'b1;
      best_nxt  = s2_deg_r;
      pick_nxt  = s2_idx_r;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_req_type)
            REQ_ADD: begin
              if (add_ok) begin
                adj_re    = 1'b1;
                adj_ra    = IDX_W'(in_vertex_a - VTX_W'(1));
                state_nxt = ST_ADD_A;
              end
            end
            REQ_RMV: begin
              if (rmv_ok) begin
                i_nxt     = '0;
                state_nxt = ST_RMV;
              end
            end
            REQ_DEG: begin
              removed_nxt = '0;
              max_nxt     = '0;
              found_nxt   = 1'b0;
              init_nxt    = 1'b1;
              i_nxt       = '0;
              state_nxt   = ST_SWEEP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD_A: begin
        // write row a, fetch row b
        adj_we              = 1'b1;
        adj_wa              = a_r;
        adj_wd              = adj_eff | (row_t'(1) << b_r);
        row_vld_nxt[a_r]    = 1'b1;
        adj_re              = 1'b1;
        adj_ra              = b_r;
        state_nxt           = ST_ADD_B;
      end
      ST_ADD_B: begin
        adj_we              = 1'b1;
        adj_wa              = b_r;
        adj_wd              = adj_eff | (row_t'(1) << a_r);
        row_vld_nxt[b_r]    = 1'b1;
        state_nxt           = ST_IDLE;
      end
      ST_RMV: begin
        adj_re = issue;
        if (s1_v_r) begin
          adj_we                = 1'b1;
          adj_wa                = s1_idx_r;
          adj_wd                = (s1_idx_r == a_r) ? '0 : (adj_eff & ~(row_t'(1) << a_r));
          row_vld_nxt[s1_idx_r] = 1'b1;
        end
        if (!issue && !s1_v_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        adj_re = issue && init_r;
        if (!issue && !s1_v_r && !s2_v_r) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        if (found_r) begin
          // peel: mark, raise the maximum, fetch the row for the next sweep
          removed_nxt[pick_r] = 1'b1;
          if (best_sat > max_r) begin
            max_nxt = best_sat;
          end
          adj_re    = 1'b1;
          adj_ra    = pick_r;
          init_nxt  = 1'b0;
          found_nxt = 1'b0;
          i_nxt     = '0;
          state_nxt = ST_SWEEP;
        end else begin
          out_valid_nxt = 1'b1;
          out_deg_nxt   = max_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vc_r        <= VC_RESET;
      i_r         <= '0;
      init_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      removed_r   <= '0;
      row_vld_r   <= '0;
      found_r     <= 1'b0;
      best_r      <= '0;
      pick_r      <= '0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
      out_deg_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      vc_r        <= vc_nxt;
      i_r         <= i_nxt;
      init_r      <= init_nxt;
      s1_v_r      <= issue;
      s2_v_r      <= s1_v_r && (state_r == ST_SWEEP);
      removed_r   <= removed_nxt;
      row_vld_r   <= row_vld_nxt;
      found_r     <= found_nxt;
      best_r      <= best_nxt;
      pick_r      <= pick_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
      out_deg_r   <= out_deg_nxt;
    end
  end

  // --- payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      a_r <= IDX_W'(in_vertex_a - VTX_W'(1));
      b_r <= IDX_W'(in_vertex_b - VTX_W'(1));
    end
    s1_idx_r <= i_r[IDX_W-1:0];
    s2_idx_r <= s1_idx_r;
    s2_deg_r <= s1_val;
  end

  // --- adjacency matrix: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    if (adj_re) begin
      adj_rd_r <= adj_mem[adj_ra];
      adj_rv_r <= row_vld_r[adj_ra];
    end
  end

  // --- degree memory: written at stage 2, read ahead at stage 0
  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      deg_mem[s2_idx_r] <= s2_deg_r;
    end
    if (deg_re) begin
      deg_rd_r <= deg_mem[i_r[IDX_W-1:0]];
    end
  end

endmodule

@@ src/gde_checker.sv @@
// ----------------------------------------------------------------------------
// gde_checker
// Port-level checks of the degeneracy engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "graph_degeneracy_engine_assert.svh"

module gde_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic [gde_pkg::REQ_W-1:0] in_req_type,
  input logic                      out_valid
);
  import gde_pkg::*;

  logic take;
  assign take = start && !busy;

  `GDE_ASSERT_NEXT(a_strobe_one, out_valid, !out_valid, "result strobe longer than one cycle")
  `GDE_ASSERT_NOW(a_strobe_end, out_valid, !busy && $past(busy), "result not at end of command")
  `GDE_ASSERT_NEXT(a_deg_busy, take && (in_req_type == REQ_DEG), busy, "compute did not go busy")
  `GDE_ASSERT_NEXT(a_no_result, take && (in_req_type != REQ_DEG), !out_valid, "result without compute")

endmodule

bind graph_degeneracy_engine gde_checker u_gde_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_req_type (in_req_type),
  .out_valid   (out_valid)
);

@@ tb/sv/graph_degeneracy_engine_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_degeneracy_engine_tb
// Self-checking bench for the k-core degeneracy engine. A scoreboard mirrors
// the adjacency matrix and peels the graph in software for every compute word.
// Directed words hit the field extremes and ignored requests. A clique is built
// and torn down vertex by vertex. Random phases then build and
// thin graphs under a range of vertex counts, including zero and oversized.
// ----------------------------------------------------------------------------
module graph_degeneracy_engine_tb;
  import gde_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;  // unused request code

  // A remove sweep holds busy over all 64 rows; wait past its end before a write.
  localparam int SETTLE_CYCLES = 80;
  // Bound on the slowest word, a compute over all 64 vertices.
  localparam longint PEEL_CYCLES = 65 * 68;
  localparam int MAX_GAP = 16;
  localparam longint ITEM_BOUND = 1000;
  localparam longint CYCLE_LIMIT = 3 * ITEM_BOUND * (PEEL_CYCLES + MAX_GAP + 4);

  localparam int NUM_PHASES = 15;
  localparam int CLIQUE_SIZE = 20;

  // --------------------------------------------------------------------------
  // Scoreboard: graph mirror, degeneracy predictor and expected-word queue
  // --------------------------------------------------------------------------
  class degeneracy_board;
    row_t adj [MAX_VERTICES];
    logic [VTX_W-1:0] vertex_count;
    logic [OUT_W-1:0] pending [$];
    int unsigned mismatches;

    function new();
      vertex_count = VC_RESET;
      mismatches = 0;
      foreach (adj[i]) adj[i] = '0;
    endfunction

    function void set_count(logic [VTX_W-1:0] value);
      vertex_count = value;
    endfunction

    function int unsigned used();
      return (int'(vertex_count) > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
    endfunction

    // Peel the lowest-numbered vertex of smallest positive degree until none
    // is left; return the largest degree seen at a peel.
    function logic [OUT_W-1:0] peel_graph();
      int unsigned n;
      int unsigned best;
      int unsigned pick;
      int unsigned top;
      int unsigned deg [MAX_VERTICES];
      bit [MAX_VERTICES-1:0] gone;
      bit found;
      n = used();
      top = 0;
      gone = '0;
      for (int v = 0; v < n; v++) begin
        deg[v] = 0;
        for (int j = 0; j < n; j++)
          if (j != v && adj[v][j]) deg[v]++;
      end
      for (int step = 0; step < n; step++) begin
        found = 0;
        best = 0;
        pick = 0;
        for (int v = 0; v < n; v++) begin
          if (!gone[v] && deg[v] != 0 && (!found || deg[v] < best)) begin
            found = 1;
            best = deg[v];
            pick = v;
          end
        end
        if (!found) break;
        gone[pick] = 1;
        if (best > top) top = best;
        for (int v = 0; v < n; v++)
          if (v != pick && !gone[v] && adj[pick][v] && deg[v] > 0) deg[v]--;
      end
      return (top > OUT_MAX) ? OUT_MAX : top[OUT_W-1:0];
    endfunction

    // Apply one accepted command word to the mirror.
    function void note_request(logic [REQ_W-1:0] req, logic [VTX_W-1:0] a,
                               logic [VTX_W-1:0] b);
      int unsigned n;
      n = used();
      case (req)
        REQ_ADD: begin
          if (a >= 1 && a <= n && b >= 1 && b <= n && a != b) begin
            adj[a-1][b-1] = 1'b1;
            adj[b-1][a-1] = 1'b1;
          end
        end
        REQ_RMV: begin
          if (a >= 1 && a <= n) begin
            for (int j = 0; j < MAX_VERTICES; j++) adj[j][a-1] = 1'b0;
            adj[a-1] = '0;
          end
        end
        REQ_DEG: pending = {pending, peel_graph()};
        default: ;
      endcase
    endfunction

    function void report(string what, logic [OUT_W-1:0] exp_val,
                         logic [OUT_W-1:0] act_val);
      if (mismatches < 10)
        $display("[%0t] %s: degeneracy expected %0d, got %0d", $time, what,
                 exp_val, act_val);
      mismatches++;
    endfunction

    function void check_result(logic [OUT_W-1:0] actual);
      logic [OUT_W-1:0] want;
      if (pending.size() == 0) begin
        report("unexpected result word", 'x, actual);
        return;
      end
      want = pending.pop_front();
      if (actual !== want) report("degeneracy mismatch", want, actual);
    endfunction

    function void flag_leftover();
      while (pending.size() != 0) report("missing result word", pending.pop_front(), 'x);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its hookup
  // --------------------------------------------------------------------------
  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [REQ_W-1:0] in_req_type;
  logic [VTX_W-1:0] in_vertex_a;
  logic [VTX_W-1:0] in_vertex_b;
  logic             out_valid;
  logic [OUT_W-1:0] out_degeneracy;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [VTX_W-1:0] cfg_vertex_count;

  degeneracy_board board;

  // Sender pacing: words left in the current burst, and the longest idle gap
  // of the running phase (zero keeps start high back to back).
  int unsigned burst_left;
  int unsigned gap_max;
  longint cycle_count;

  // Random phase plan: vertex count, number of words, longest sender gap.
  int unsigned plan_count [NUM_PHASES] =
    '{8, 0, 1, 12, 127, 3, 20, 64, 2, 65, 5, 30, 10, 100, 16};
  int unsigned plan_items [NUM_PHASES] =
    '{70, 10, 10, 70, 50, 20, 70, 60, 15, 50, 40, 60, 70, 40, 60};
  int unsigned plan_gap [NUM_PHASES] =
    '{6, 3, 0, 0, 8, 4, 5, 3, 0, 6, 2, 0, 7, 4, 3};

  graph_degeneracy_engine i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_vertex_a      (in_vertex_a),
    .in_vertex_b      (in_vertex_b),
    .out_valid        (out_valid),
    .out_degeneracy   (out_degeneracy),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_vertex_count (cfg_vertex_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Sample the result strobe at the edge that ends its one-cycle window.
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_degeneracy);
  end

  // Hang guard: give up well past the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Present one command word and hold it until the engine takes it, then
  // either keep start high for the next word or drop it for a random gap.
  task automatic issue(logic [REQ_W-1:0] req, logic [VTX_W-1:0] a,
                       logic [VTX_W-1:0] b);
    int unsigned idle;
    @(negedge clk);
    start       <= 1'b1;
    in_req_type <= req;
    in_vertex_a <= a;
    in_vertex_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(req, a, b);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && gap_max > 0) begin
      burst_left = $urandom_range(1, 16);
      idle = $urandom_range(1, gap_max);
      @(negedge clk);
      start <= 1'b0;
      repeat (idle - 1) @(negedge clk);
    end
  endtask

  // Drop start, wait out every expected word and let any trailing add or
  // remove sweep finish, so the engine is idle.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the vertex count while idle; hold valid until ready.
  task automatic write_count(logic [VTX_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_vertex_count <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_count(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random word: mostly well-formed graph edits on in-range vertices,
  // some computes, and the rest noise over the full field ranges.
  task automatic random_item(int unsigned n);
    int unsigned roll;
    logic [REQ_W-1:0] req;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    roll = $urandom_range(0, 99);
    a = VTX_W'($urandom_range(0, 127));
    b = VTX_W'($urandom_range(0, 127));
    if (roll < 55 && n >= 2) begin
      req = REQ_ADD;
      a = VTX_W'($urandom_range(1, n));
      b = VTX_W'($urandom_range(1, n - 1));
      if (b >= a) b++;
    end else if (roll < 67 && n >= 1) begin
      req = REQ_RMV;
      a = VTX_W'($urandom_range(1, n));
    end else if (roll < 82) begin
      req = REQ_DEG;
    end else begin
      req = REQ_W'($urandom_range(0, 3));
    end
    issue(req, a, b);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_req_type      = REQ_ADD;
    in_vertex_a      = '0;
    in_vertex_b      = '0;
    cfg_valid        = 1'b0;
    cfg_vertex_count = VC_RESET;
    cycle_count      = 0;
    burst_left       = 0;
    gap_max          = 2;
    board            = new();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words at the reset vertex count of 64.
    issue(REQ_DEG, 7'd127, 7'd0);   // empty graph peels to zero
    issue(REQ_ADD, 7'd1, 7'd64);    // both ends of the vertex range
    issue(REQ_ADD, 7'd64, 7'd1);    // repeat edge, no change
    issue(REQ_ADD, 7'd5, 7'd5);     // self-loop, drop
    issue(REQ_ADD, 7'd0, 7'd3);     // vertex zero, drop
    issue(REQ_ADD, 7'd3, 7'd65);    // above the count, drop
    issue(REQ_ADD, 7'd127, 7'd127);
    issue(REQ_ADD, 7'd2, 7'd3);
    issue(REQ_ADD, 7'd3, 7'd1);
    issue(REQ_ADD, 7'd1, 7'd2);     // triangle plus a pendant vertex
    issue(REQ_DEG, 7'd0, 7'd127);
    issue(REQ_RMV, 7'd0, 7'd0);     // out-of-range removes, drop
    issue(REQ_RMV, 7'd65, 7'd64);
    issue(REQ_RMV, 7'd127, 7'd1);
    issue(REQ_NONE, 7'd127, 7'd127);
    issue(REQ_NONE, 7'd0, 7'd0);
    issue(REQ_RMV, 7'd2, 7'd0);     // break the triangle
    issue(REQ_DEG, 7'd64, 7'd1);
    issue(REQ_RMV, 7'd64, 7'd0);
    issue(REQ_RMV, 7'd1, 7'd0);
    issue(REQ_RMV, 7'd3, 7'd0);
    issue(REQ_RMV, 7'd3, 7'd0);     // already gone
    issue(REQ_DEG, 7'd33, 7'd94);

    // A clique peels at one below its size; then drop one vertex and clear
    // the rest. Run back to back.
    write_count(VC_RESET);
    gap_max = 0;
    for (int i = 1; i <= CLIQUE_SIZE; i++)
      for (int j = i + 1; j <= CLIQUE_SIZE; j++)
        issue(REQ_ADD, VTX_W'(i), VTX_W'(j));
    issue(REQ_DEG, 7'd0, 7'd0);
    issue(REQ_RMV, VTX_W'(CLIQUE_SIZE), 7'd0);
    issue(REQ_DEG, 7'd0, 7'd0);
    for (int i = 1; i < CLIQUE_SIZE; i++) issue(REQ_RMV, VTX_W'(i), 7'd0);
    issue(REQ_DEG, 7'd0, 7'd0);

    // Random phases; the graph carries over, so lowered counts leave stale
    // edges in the matrix that the engine has to ignore.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_count(VTX_W'(plan_count[p]));
      gap_max = plan_gap[p];
      burst_left = 0;
      for (int k = 0; k < plan_items[p]; k++) random_item(board.used());
    end

    drain();
    board.flag_leftover();
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
